### rtl/bced_pkg.sv
// Shared types, constants and codes of the button click event detector.
package bced_pkg;

   localparam int TIME_WIDTH     = 32;
   localparam int PORT_WIDTH     = 8;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic [TIME_WIDTH-1:0]      time_type;
   typedef logic [PORT_WIDTH-1:0]      port_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_CLICK  = 3'd1,
      EV_DOUBLE = 3'd2,
      EV_TRIPLE = 3'd3,
      EV_LONG   = 3'd4
   } event_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_CANCEL = 1'b1
   } op_type;

   localparam csr_index_type CSR_BUTTON_MASK       = 3'd0;
   localparam csr_index_type CSR_LONG_PRESS_LIMIT  = 3'd1;
   localparam csr_index_type CSR_MULTICLICK_ENABLE = 3'd2;
   localparam csr_index_type CSR_DEBOUNCE_TIME     = 3'd3;
   localparam csr_index_type CSR_REPORT_WINDOW     = 3'd4;
   localparam csr_index_type CSR_REPEAT_DELAY      = 3'd5;

   localparam port_type     RESET_BUTTON_MASK      = port_type'(1);
   localparam logic [15:0]  RESET_LONG_PRESS_LIMIT = 16'd0;
   localparam logic         RESET_MULTICLICK       = 1'b1;
   localparam logic [7:0]   RESET_DEBOUNCE_TIME    = 8'd40;
   localparam logic [15:0]  RESET_REPORT_WINDOW    = 16'd280;
   localparam logic [15:0]  RESET_REPEAT_DELAY     = 16'd700;

   localparam logic [1:0]   TALLY_MAX = 2'd3;

   typedef struct packed {
      port_type    button_mask;
      logic [15:0] long_press_limit;
      logic        multiclick_enable;
      logic [7:0]  debounce_time;
      logic [15:0] report_window;
      logic [15:0] repeat_delay;
   } cfg_type;

   typedef struct packed {
      logic       raw_level;
      logic       stable_level;
      time_type   raw_change_time;
      time_type   press_time;
      logic       press_valid;
      time_type   last_click_time;
      logic [1:0] click_tally;
      logic       click_pending;
      logic       cancel_flag;
   } state_type;

endpackage

### rtl/bced_req_if.sv
// Sample channel: valid, ready and one sample item.
interface bced_req_if import bced_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     operation;
   time_type now_ms;
   port_type port_state;
   logic     repeat_enable;

   modport source (output valid, output operation, output now_ms, output port_state,
                   output repeat_enable, input ready);
   modport sink (input valid, input operation, input now_ms, input port_state,
                 input repeat_enable, output ready);
endinterface

### rtl/bced_rsp_if.sv
// Result channel: valid, ready and one event item.
interface bced_rsp_if import bced_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic       debounced_pressed;

   modport source (output valid, output event_res, output debounced_pressed, input ready);
   modport sink (input valid, input event_res, input debounced_pressed, output ready);
endinterface

### rtl/bced_eval.sv
// Next-state and event logic for one sample or cancel item.
module bced_eval import bced_pkg::*; (
   input  cfg_type   cfg,
   input  state_type cur,
   input  logic      operation,
   input  time_type  now_ms,
   input  port_type  port_state,
   input  logic      repeat_enable,
   output state_type nxt,
   output event_type ev
);

   logic     raw;
   logic     short_hold;
   time_type win;

   always_comb begin
      nxt        = cur;
      ev         = EV_NONE;
      raw        = 1'b0;
      short_hold = 1'b0;
      win        = '0;
      if (op_type'(operation) == OP_CANCEL) begin
         nxt.cancel_flag     = 1'b1;
         nxt.press_valid     = 1'b0;
         nxt.press_time      = '0;
         nxt.click_tally     = '0;
         nxt.last_click_time = '0;
         nxt.click_pending   = 1'b0;
      end else begin
         raw = (port_state & cfg.button_mask) != cfg.button_mask;
         if (raw != cur.raw_level) begin
            nxt.raw_level       = raw;
            nxt.raw_change_time = now_ms;
         end

         if (nxt.raw_level != cur.stable_level &&
             time_type'(now_ms - nxt.raw_change_time) >= time_type'(cfg.debounce_time)) begin
            if (nxt.raw_level) begin
               nxt.press_time  = now_ms;
               nxt.press_valid = 1'b1;
            end else begin
               short_hold = cur.press_valid &&
                  time_type'(now_ms - cur.press_time) < time_type'(cfg.long_press_limit);
               if (cfg.long_press_limit == '0 || short_hold) begin
                  if (cur.click_tally != TALLY_MAX) begin
                     nxt.click_tally = cur.click_tally + 2'd1;
                  end
                  nxt.last_click_time = now_ms;
                  nxt.click_pending   = 1'b1;
               end
               nxt.press_valid = 1'b0;
               nxt.press_time  = '0;
            end
            nxt.stable_level = nxt.raw_level;
         end

         if (!nxt.stable_level) begin
            nxt.cancel_flag = 1'b0;
         end

         if (cfg.long_press_limit != '0 && nxt.press_valid &&
             time_type'(now_ms - nxt.press_time) >= time_type'(cfg.long_press_limit)) begin
            if (nxt.click_pending) begin
               nxt.cancel_flag = 1'b1;
            end else begin
               ev = EV_LONG;
            end
            nxt.press_valid     = 1'b0;
            nxt.press_time      = '0;
            nxt.click_tally     = '0;
            nxt.last_click_time = '0;
            nxt.click_pending   = 1'b0;
         end

         if (nxt.stable_level && repeat_enable && nxt.press_valid &&
             time_type'(now_ms - nxt.press_time) >= time_type'(cfg.repeat_delay)) begin
            ev = EV_CLICK;
         end

         win = cfg.multiclick_enable ? time_type'(cfg.report_window) : '0;
         if (nxt.click_pending && !nxt.stable_level &&
             time_type'(now_ms - nxt.last_click_time) >= win) begin
            if (!nxt.cancel_flag) begin
               case (nxt.click_tally)
                  2'd1:    ev = EV_CLICK;
                  2'd2:    ev = EV_DOUBLE;
                  default: ev = EV_TRIPLE;
               endcase
            end
            nxt.click_tally     = '0;
            nxt.last_click_time = '0;
            nxt.click_pending   = 1'b0;
         end
      end
   end

endmodule

### rtl/button_click_event_detector_unit.sv
// Top level of the button click event detector.
//
// Usage:
// - req_chan carries sample items (operation, now_ms, port_state, repeat_enable)
//   with valid/ready; a transfer happens when both are high at a clock edge.
// - rsp_chan returns one item per accepted input: event_res and the debounced
//   level, held in a result register until the receiver takes it.
// - The csr_ port writes one of six registers per cycle when csr_write_enable
//   is high; write only while no item is in flight.
// rsp_chan.valid rises in the cycle after an input transfer. One item is
// accepted every cycle while the receiver takes results; the evaluation of a sample
// sits in a single stage between the state registers and the result register.
// When the receiver stalls, the result register holds its item and req_chan
// stays ready only while that register is being emptied in the same cycle.
// Reset (synchronous, active high) loads the register defaults, clears all
// tracking state and empties the result register.
module button_click_event_detector_unit import bced_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bced_req_if.sink          req_chan,
   bced_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  csr_index_type     csr_index,
   input  csr_data_type      csr_write_data
);

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_nxt;
   event_type ev;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [2:0] event_res_ff;
   logic      pressed_ff;
   logic      take;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;

   bced_eval u_eval (
      .cfg           (cfg_ff),
      .cur           (state_ff),
      .operation     (req_chan.operation),
      .now_ms        (req_chan.now_ms),
      .port_state    (req_chan.port_state),
      .repeat_enable (req_chan.repeat_enable),
      .nxt           (state_nxt),
      .ev            (ev)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BUTTON_MASK:       cfg_in.button_mask       = csr_write_data[PORT_WIDTH-1:0];
            CSR_LONG_PRESS_LIMIT:  cfg_in.long_press_limit  = csr_write_data[15:0];
            CSR_MULTICLICK_ENABLE: cfg_in.multiclick_enable = csr_write_data[0];
            CSR_DEBOUNCE_TIME:     cfg_in.debounce_time     = csr_write_data[7:0];
            CSR_REPORT_WINDOW:     cfg_in.report_window     = csr_write_data[15:0];
            CSR_REPEAT_DELAY:      cfg_in.repeat_delay      = csr_write_data[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_mask       <= RESET_BUTTON_MASK;
         cfg_ff.long_press_limit  <= RESET_LONG_PRESS_LIMIT;
         cfg_ff.multiclick_enable <= RESET_MULTICLICK;
         cfg_ff.debounce_time     <= RESET_DEBOUNCE_TIME;
         cfg_ff.report_window     <= RESET_REPORT_WINDOW;
         cfg_ff.repeat_delay      <= RESET_REPEAT_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (take) begin
         state_ff <= state_nxt;
      end
   end

   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload while the receiver stalls
   always_ff @(posedge clock) begin
      if (take) begin
         event_res_ff <= 3'(ev);
         pressed_ff   <= state_nxt.stable_level;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.event_res         = event_res_ff;
   assign rsp_chan.debounced_pressed = pressed_ff;

endmodule
